FILE: design/suks_pkg.sv
// Shared types and constants for the sorted unique key set.
// Holds the request codes, the fixed field widths and the compare status struct.
// No dependencies; every other design file refers to it by scoped names.
package suks_pkg;

  // Field widths of the request and response transactions
  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned KEY_IN_W   = 16;
  localparam int unsigned COUNT_W    = 7;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_CAPACITY  = 64;
  localparam int unsigned DEF_KEY_WIDTH = 16;

  // Request codes; code 3 is unused and answered without any change
  localparam logic [REQ_TYPE_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_DELETE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_LOOKUP = 2'd2;

  // Result of comparing the stored key on the read port against the request key
  typedef struct packed {
    logic lt;  // stored key below request key
    logic eq;  // stored key equal to request key
  } cmp_t;

endpackage

FILE: design/suks_if.sv
// Handshake interfaces for the request and response channels of the key set.
// Depends on suks_pkg for the field widths.
interface suks_req_if;
  logic                              valid;
  logic                              ready;
  logic [suks_pkg::REQ_TYPE_W-1:0]   req_type;
  logic [suks_pkg::KEY_IN_W-1:0]     key;

  modport source (output valid, req_type, key, input ready);
  modport sink   (input valid, req_type, key, output ready);
endinterface

interface suks_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           success;
  logic                           store_full;
  logic [suks_pkg::COUNT_W-1:0]   key_count;

  modport source (output valid, success, store_full, key_count, input ready);
  modport sink   (input valid, success, store_full, key_count, output ready);
endinterface

FILE: design/suks_store.sv
// Key memory of the sorted set with one write port, one registered read port
// and the single shared magnitude comparator. Depends on suks_pkg.
module suks_store #(
  parameter int unsigned CAPACITY  = suks_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_WIDTH = suks_pkg::DEF_KEY_WIDTH,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [KEY_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  input  logic [KEY_WIDTH-1:0] key,
  output logic [KEY_WIDTH-1:0] rd_data,
  output suks_pkg::cmp_t       cmp
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_data_r;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

  // Compare the last read entry against the request key
  always_comb begin
    cmp.lt = rd_data_r < key;
    cmp.eq = rd_data_r == key;
  end

endmodule

FILE: design/sorted_unique_key_set.sv
// Sorted unique key set: top level with the request sequencer.
// Depends on suks_pkg, suks_if (suks_req_if, suks_rsp_if) and suks_store.
//
// Usage:
//   in_req  : request transactions (req_type, key). req_type 0 inserts, 1 deletes,
//             2 looks up the key; code 3 is answered without change. Only the low
//             KEY_WIDTH bits of key count.
//   out_rsp : one response transaction per request: success, store_full and
//             key_count, the number of keys held after the request.
//   Keys sit in ascending order in a CAPACITY-entry memory. A serial scan reads one
//   entry per cycle up to the first key not below the request key; an insert or
//   delete then moves the tail of the list one entry per cycle.
//   An empty set skips the scan and goes straight to the decision.
//   in_req.ready is high only while the sequencer waits for a request. A finished
//   response waits in an output register while the next request is taken; only the
//   following response waits on out_rsp.ready.
//   Reset (rst_n low, synchronous) empties the set and drops any pending response;
//   memory is not cleared, entries at or above the count are never used.
module sorted_unique_key_set #(
  parameter int unsigned CAPACITY  = suks_pkg::DEF_CAPACITY,
  parameter int unsigned KEY_WIDTH = suks_pkg::DEF_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  suks_req_if.sink    in_req,
  suks_rsp_if.source  out_rsp
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SCAN   = 7'b0000010,
    ST_DECIDE = 7'b0000100,
    ST_INS    = 7'b0001000,
    ST_PUT    = 7'b0010000,
    ST_DEL    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [suks_pkg::REQ_TYPE_W-1:0] req_r, req_nxt;
  logic [KEY_WIDTH-1:0]            key_r, key_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  logic [CW-1:0]                   pos_r, pos_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   dst_r, dst_nxt;
  logic                            rdv_r, rdv_nxt;
  logic                            present_r, present_nxt;
  logic                            ok_r, ok_nxt;
  logic                            full_r, full_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic                            out_succ_r, out_succ_nxt;
  logic                            out_full_r, out_full_nxt;
  logic [suks_pkg::COUNT_W-1:0]    out_cnt_r, out_cnt_nxt;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [AW-1:0]        rd_addr;
  logic [KEY_WIDTH-1:0] rd_data;
  suks_pkg::cmp_t       cmp;

  suks_store #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .key     (key_r),
    .rd_data (rd_data),
    .cmp     (cmp)
  );

  assign in_req.ready       = (state_r == ST_IDLE);
  assign out_rsp.valid      = out_vld_r;
  assign out_rsp.success    = out_succ_r;
  assign out_rsp.store_full = out_full_r;
  assign out_rsp.key_count  = out_cnt_r;

  // Sequencer: scan for the sorted place, then, for an insert or delete, shift and write
  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    key_nxt      = key_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    idx_nxt      = idx_r;
    dst_nxt      = dst_r;
    rdv_nxt      = rdv_r;
    present_nxt  = present_r;
    ok_nxt       = ok_r;
    full_nxt     = full_r;
    out_vld_nxt  = out_vld_r;
    out_succ_nxt = out_succ_r;
    out_full_nxt = out_full_r;
    out_cnt_nxt  = out_cnt_r;
    rd_addr      = idx_r[AW-1:0];
    wr_en        = 1'b0;
    wr_addr      = dst_r[AW-1:0];
    wr_data      = rd_data;

    // Drop the response once the receiver takes it
    if (out_vld_r && out_rsp.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          req_nxt     = in_req.req_type;
          key_nxt     = KEY_WIDTH'(in_req.key);
          idx_nxt     = '0;
          rdv_nxt     = 1'b0;
          pos_nxt     = '0;
          present_nxt = 1'b0;
          state_nxt   = (count_r == '0) ? ST_DECIDE : ST_SCAN;
        end
      end

      // Read one entry per cycle; compare the entry read in the previous cycle
      ST_SCAN: begin
        idx_nxt = idx_r + ONE;
        rdv_nxt = 1'b1;
        if (rdv_r) begin
          if (!cmp.lt) begin
            pos_nxt     = idx_r - ONE;
            present_nxt = cmp.eq;
            state_nxt   = ST_DECIDE;
          end else if (idx_r == count_r) begin
            pos_nxt     = count_r;
            present_nxt = 1'b0;
            state_nxt   = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        rdv_nxt   = 1'b0;
        ok_nxt    = 1'b0;
        full_nxt  = 1'b0;
        state_nxt = ST_DONE;
        case (req_r)
          suks_pkg::REQ_INSERT: begin
            if (!present_r) begin
              if (count_r == CAP_CNT) begin
                full_nxt = 1'b1;
              end else begin
                ok_nxt = 1'b1;
                if (pos_r == count_r) begin
                  state_nxt = ST_PUT;
                end else begin
                  idx_nxt   = count_r - ONE;
                  dst_nxt   = count_r;
                  state_nxt = ST_INS;
                end
              end
            end
          end
          suks_pkg::REQ_DELETE: begin
            if (present_r) begin
              ok_nxt = 1'b1;
              if (pos_r + ONE == count_r) begin
                count_nxt = count_r - ONE;
              end else begin
                idx_nxt   = pos_r + ONE;
                dst_nxt   = pos_r;
                state_nxt = ST_DEL;
              end
            end
          end
          suks_pkg::REQ_LOOKUP: begin
            ok_nxt = present_r;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end

      // Move entries up by one, from the top down to the sorted place
      ST_INS: begin
        idx_nxt = idx_r - ONE;
        rdv_nxt = 1'b1;
        if (rdv_r) begin
          wr_en   = 1'b1;
          dst_nxt = dst_r - ONE;
          if (dst_r == pos_r + ONE) begin
            state_nxt = ST_PUT;
          end
        end
      end

      // Write the new key into the freed place
      ST_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[AW-1:0];
        wr_data   = key_r;
        count_nxt = count_r + ONE;
        state_nxt = ST_DONE;
      end

      // Move entries down by one over the deleted place
      ST_DEL: begin
        idx_nxt = idx_r + ONE;
        rdv_nxt = 1'b1;
        if (rdv_r) begin
          wr_en   = 1'b1;
          dst_nxt = dst_r + ONE;
          if (dst_r + ONE == count_r - ONE) begin
            count_nxt = count_r - ONE;
            state_nxt = ST_DONE;
          end
        end
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_vld_r || out_rsp.ready) begin
          out_vld_nxt  = 1'b1;
          out_succ_nxt = ok_r;
          out_full_nxt = full_r;
          out_cnt_nxt  = suks_pkg::COUNT_W'(count_r);
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rdv_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rdv_r     <= rdv_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    key_r      <= key_nxt;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    dst_r      <= dst_nxt;
    present_r  <= present_nxt;
    ok_r       <= ok_nxt;
    full_r     <= full_nxt;
    out_succ_r <= out_succ_nxt;
    out_full_r <= out_full_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  // The set never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("key count above capacity");

  // The count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r) || count_r == $past(count_r) + ONE ||
              count_r == $past(count_r) - ONE))
    else $error("key count jumped");

  // A refused insert reports a full store and no success
  a_full_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_full_r) |->
      (!out_succ_r && out_cnt_r == suks_pkg::COUNT_W'(CAP_CNT)))
    else $error("full flag with inconsistent response");

  // The memory is written only while shifting or placing a key
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_INS || state_r == ST_PUT || state_r == ST_DEL))
    else $error("memory write outside an update");

endmodule
